// ----- hw/rtl/grid_plane_index_generator_macros.svh -----
// assertion macros used by the grid plane index generator back end
`ifndef GRID_PLANE_INDEX_GENERATOR_MACROS_SVH
`define GRID_PLANE_INDEX_GENERATOR_MACROS_SVH

// same-cycle implication, checked on clk_i, off during reset
`define GPIG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define GPIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gpig_pkg.sv -----
// shared types and constants of the grid plane index generator
package gpig_pkg;

  // fixed field widths
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned IDX_W       = 21;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned PATCH_W     = 2;

  // default largest cell count per side
  localparam int unsigned MAX_CELLS_DEFAULT = 1024;

  // depth of the descriptor queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_CELLS  = 2'd0,
    CFG_PATCH_MODE = 2'd1,
    CFG_ADD_SKIRT  = 2'd2
  } cfg_idx_e;

  // patch mode codes
  localparam logic [PATCH_W-1:0] PM_TRI   = 2'd0;
  localparam logic [PATCH_W-1:0] PM_QUAD  = 2'd1;
  localparam logic [PATCH_W-1:0] PM_PATCH = 2'd2;

  // which index sequence follows a vertex
  typedef enum logic [1:0] {
    IDX_NONE,
    IDX_TRI,
    IDX_QUAD,
    IDX_PATCH
  } idx_kind_e;

  // last result number of each sequence
  localparam logic [3:0] LAST_K_ONE   = 4'd0;
  localparam logic [3:0] LAST_K_TRI   = 4'd5;
  localparam logic [3:0] LAST_K_QUAD  = 4'd3;
  localparam logic [3:0] LAST_K_PATCH = 4'd15;

  // one classified vertex, or a done marker, handed from front to back
  typedef struct packed {
    logic                 done;
    idx_kind_e            kind;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic                 skirt;
    logic [IDX_W-1:0]     row_base;
    logic [IDX_W-1:0]     col;
    logic [IDX_W-1:0]     prv_off;
    logic [IDX_W-1:0]     patch_off;
    logic [IDX_W-1:0]     stride;
  } desc_t;

endpackage

// ----- hw/rtl/grid_plane_index_generator.sv -----
// top level of the grid plane index generator: config registers, front, queue, back
//
// Input channel: in_valid_i / in_stall_o with restart_i. Each accepted beat asks for
// one vertex: restart_i = 1 starts the walk at vertex zero, 0 takes the next vertex.
// Result channel: out_valid_o / out_stall_i, one result beat per cycle at most.
// A vertex gives 1, 4, 6 or 16 result beats (no indices, quad, two triangles,
// patch); the last beat of each input carries last_o. An advance past the end of
// the grid gives a single beat with grid_done_o set.
// The first result beat of an input passes the descriptor queue, the active
// descriptor registers and the output register. The back end's result sequencer
// gives one result beat per cycle while out_stall_i is low, and takes the next
// descriptor as it emits the last beat of the current one. The front takes one
// beat a cycle while the two-entry descriptor queue has room, and stalls the input
// only when it is full. When out_stall_i is high the current result beat holds; the
// back end waits and the queue fills, after which in_stall_o rises.
// Reset: num_cells = 1, patch_mode = 0, add_skirt = 0, the walk is finished until a
// restart, and both channels are empty. Config writes go through cfg_we_i,
// cfg_idx_i and cfg_data_i; write only while no results are outstanding.
module grid_plane_index_generator import gpig_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  has_vertex_o,
  output logic [COORD_W-1:0]    vertex_x_o,
  output logic [COORD_W-1:0]    vertex_y_o,
  output logic                  skirt_o,
  output logic                  index_valid_o,
  output logic [IDX_W-1:0]      vertex_index_o,
  output logic                  last_o,
  output logic                  grid_done_o
);

  logic [CFG_DATA_W-1:0] num_cells_q;
  logic [PATCH_W-1:0]    patch_mode_q;
  logic                  add_skirt_q;

  logic  push, full, pop, head_valid;
  desc_t push_desc, head_desc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cells_q  <= CFG_DATA_W'(1);
      patch_mode_q <= PM_TRI;
      add_skirt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_CELLS:  num_cells_q  <= cfg_data_i;
        CFG_PATCH_MODE: patch_mode_q <= cfg_data_i[PATCH_W-1:0];
        CFG_ADD_SKIRT:  add_skirt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // walker and classifier
  gpig_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .restart_i    (restart_i),
    .num_cells_i  (num_cells_q),
    .patch_mode_i (patch_mode_q),
    .add_skirt_i  (add_skirt_q),
    .full_i       (full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // descriptor queue
  gpig_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_desc)
  );

  // result sequencer
  gpig_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_desc),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .has_vertex_o   (has_vertex_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .skirt_o        (skirt_o),
    .index_valid_o  (index_valid_o),
    .vertex_index_o (vertex_index_o),
    .last_o         (last_o),
    .grid_done_o    (grid_done_o)
  );

endmodule

// ----- hw/rtl/gpig_front.sv -----
// front part: grid walker that accepts input beats and classifies each vertex
module gpig_front import gpig_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  restart_i,
  input  logic [CFG_DATA_W-1:0] num_cells_i,
  input  logic [PATCH_W-1:0]    patch_mode_i,
  input  logic                  add_skirt_i,
  input  logic                  full_i,
  output logic                  push_o,
  output desc_t                 desc_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CELLS + 4);

  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic [1:0]         col_m3_q, col_m3_d, row_m3_q, row_m3_d;
  logic               fin_q, fin_d;

  logic               accept;
  logic [CNT_W-1:0]   n, count, outer, w, h, wm1, hm1, w_inc, h_inc;
  logic [1:0]         wm3, hm3;
  logic               fin, is_done;
  logic [2*CNT_W-1:0] prod;
  logic [IDX_W-1:0]   cnt_x;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  // effective cell count and row stride
  always_comb begin
    if (num_cells_i == '0) begin
      n = CNT_W'(1);
    end else if (32'(num_cells_i) > 32'(MAX_CELLS)) begin
      n = CNT_W'(MAX_CELLS);
    end else begin
      n = CNT_W'(num_cells_i);
    end
  end
  assign count = n + CNT_W'(add_skirt_i ? 3 : 1);
  assign outer = n + CNT_W'(2);

  // position of this beat, restart takes vertex zero
  assign w       = restart_i ? '0 : col_q;
  assign h       = restart_i ? '0 : row_q;
  assign wm3     = restart_i ? '0 : col_m3_q;
  assign hm3     = restart_i ? '0 : row_m3_q;
  assign fin     = restart_i ? 1'b0 : fin_q;
  assign is_done = fin || (h >= count) || (w >= count);
  assign wm1     = w - CNT_W'(1);
  assign hm1     = h - CNT_W'(1);
  assign w_inc   = w + CNT_W'(1);
  assign h_inc   = h + CNT_W'(1);

  // row base product
  assign prod  = {{CNT_W{1'b0}}, h} * {{CNT_W{1'b0}}, count};
  assign cnt_x = IDX_W'(count);

  // classify the vertex
  always_comb begin
    desc_o.done      = is_done;
    desc_o.row_base  = IDX_W'(prod);
    desc_o.col       = IDX_W'(w);
    desc_o.prv_off   = cnt_x - IDX_W'(w);
    desc_o.patch_off = (cnt_x << 1) + cnt_x + IDX_W'(3) - IDX_W'(w);
    desc_o.stride    = cnt_x;
    if (add_skirt_i) begin
      desc_o.x     = (w == '0) ? '0 : COORD_W'((wm1 > n) ? n : wm1);
      desc_o.y     = (h == '0) ? '0 : COORD_W'((hm1 > n) ? n : hm1);
      desc_o.skirt = (w == '0) || (h == '0) || (w == outer) || (h == outer);
    end else begin
      desc_o.x     = COORD_W'(w);
      desc_o.y     = COORD_W'(h);
      desc_o.skirt = 1'b0;
    end
    desc_o.kind = IDX_NONE;
    if ((w != '0) && (h != '0)) begin
      case (patch_mode_i)
        PM_TRI:   desc_o.kind = IDX_TRI;
        PM_QUAD:  desc_o.kind = IDX_QUAD;
        PM_PATCH: desc_o.kind = ((wm3 == 2'd0) && (hm3 == 2'd0)) ? IDX_PATCH : IDX_NONE;
        default:  desc_o.kind = IDX_NONE;
      endcase
    end
  end

  // walker advance
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    col_m3_d = col_m3_q;
    row_m3_d = row_m3_q;
    fin_d    = fin_q;
    if (accept) begin
      col_d    = w;
      row_d    = h;
      col_m3_d = wm3;
      row_m3_d = hm3;
      fin_d    = fin;
      if (is_done) begin
        fin_d = 1'b1;
      end else begin
        col_d    = w_inc;
        col_m3_d = (wm3 == 2'd2) ? 2'd0 : wm3 + 2'd1;
        if (w_inc >= count) begin
          col_d    = '0;
          col_m3_d = 2'd0;
          row_d    = h_inc;
          row_m3_d = (hm3 == 2'd2) ? 2'd0 : hm3 + 2'd1;
          if (h_inc >= count) begin
            row_d    = '0;
            row_m3_d = 2'd0;
            fin_d    = 1'b1;
          end
        end
      end
    end
  end

  // walker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      col_m3_q <= 2'd0;
      row_m3_q <= 2'd0;
      fin_q    <= 1'b1;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      col_m3_q <= col_m3_d;
      row_m3_q <= row_m3_d;
      fin_q    <= fin_d;
    end
  end

endmodule

// ----- hw/rtl/gpig_fifo.sv -----
// short descriptor queue between front and back
module gpig_fifo import gpig_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output desc_t data_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  desc_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/gpig_back.sv -----
// back part: expands each descriptor into result beats through an output register
module gpig_back import gpig_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  desc_t              head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               has_vertex_o,
  output logic [COORD_W-1:0] vertex_x_o,
  output logic [COORD_W-1:0] vertex_y_o,
  output logic               skirt_o,
  output logic               index_valid_o,
  output logic [IDX_W-1:0]   vertex_index_o,
  output logic               last_o,
  output logic               grid_done_o
);

`include "grid_plane_index_generator_macros.svh"

  // active descriptor
  logic               act_valid_q, act_valid_d;
  logic               act_done_q;
  idx_kind_e          act_kind_q;
  logic [COORD_W-1:0] act_x_q, act_y_q;
  logic               act_skirt_q;
  logic [IDX_W-1:0]   stride_q, cur_q, prv_q, rowp_q, rowp_d;
  logic [3:0]         k_q, k_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_hv_q, out_skirt_q, out_iv_q, out_last_q, out_done_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [IDX_W-1:0]   out_idx_q;

  logic               emit, is_last, hv, iv;
  logic [3:0]         last_k;
  logic [IDX_W-1:0]   idx;

  // length of the active sequence
  always_comb begin
    if (act_done_q) begin
      last_k = LAST_K_ONE;
    end else begin
      case (act_kind_q)
        IDX_TRI:   last_k = LAST_K_TRI;
        IDX_QUAD:  last_k = LAST_K_QUAD;
        IDX_PATCH: last_k = LAST_K_PATCH;
        default:   last_k = LAST_K_ONE;
      endcase
    end
  end

  assign is_last = (k_q == last_k);
  assign emit    = act_valid_q && (!out_valid_q || !out_stall_i);
  assign pop_o   = head_valid_i && (!act_valid_q || (emit && is_last));
  assign hv      = !act_done_q && (k_q == 4'd0);
  assign iv      = !act_done_q && (act_kind_q != IDX_NONE);

  // index of this result
  always_comb begin
    case (act_kind_q)
      IDX_TRI: begin
        case (k_q)
          4'd0, 4'd5: idx = cur_q;
          4'd1:       idx = cur_q - IDX_W'(1);
          4'd2, 4'd3: idx = prv_q - IDX_W'(1);
          default:    idx = prv_q;
        endcase
      end
      IDX_QUAD: begin
        case (k_q)
          4'd0:    idx = cur_q;
          4'd1:    idx = cur_q - IDX_W'(1);
          4'd2:    idx = prv_q - IDX_W'(1);
          default: idx = prv_q;
        endcase
      end
      IDX_PATCH: idx = rowp_q + IDX_W'(k_q[1:0]);
      default:   idx = '0;
    endcase
  end

  // sequencer next state
  always_comb begin
    act_valid_d = act_valid_q;
    k_d         = k_q;
    rowp_d      = rowp_q;
    if (emit) begin
      k_d = k_q + 4'd1;
      if (is_last) begin
        act_valid_d = 1'b0;
      end
      if ((act_kind_q == IDX_PATCH) && (k_q[1:0] == 2'd3)) begin
        rowp_d = rowp_q + stride_q;
      end
    end
    if (pop_o) begin
      act_valid_d = 1'b1;
      k_d         = 4'd0;
      rowp_d      = head_i.row_base - head_i.patch_off;
    end
    out_valid_d = emit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      k_q         <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      act_valid_q <= act_valid_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // descriptor load and index bases
  always_ff @(posedge clk_i) begin
    rowp_q <= rowp_d;
    if (pop_o) begin
      act_done_q  <= head_i.done;
      act_kind_q  <= head_i.kind;
      act_x_q     <= head_i.x;
      act_y_q     <= head_i.y;
      act_skirt_q <= head_i.skirt;
      stride_q    <= head_i.stride;
      cur_q       <= head_i.row_base + head_i.col;
      prv_q       <= head_i.row_base - head_i.prv_off;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_hv_q    <= hv;
      out_x_q     <= hv ? act_x_q : '0;
      out_y_q     <= hv ? act_y_q : '0;
      out_skirt_q <= hv && act_skirt_q;
      out_iv_q    <= iv;
      out_idx_q   <= iv ? idx : '0;
      out_last_q  <= is_last;
      out_done_q  <= act_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_vertex_o   = out_hv_q;
  assign vertex_x_o     = out_x_q;
  assign vertex_y_o     = out_y_q;
  assign skirt_o        = out_skirt_q;
  assign index_valid_o  = out_iv_q;
  assign vertex_index_o = out_idx_q;
  assign last_o         = out_last_q;
  assign grid_done_o    = out_done_q;

  // checks
  `GPIG_ASSERT_IMPL(a_vertex_not_done, out_valid_q && out_hv_q, !out_done_q, "vertex beat marked done")
  `GPIG_ASSERT_IMPL(a_done_is_last, out_valid_q && out_done_q, out_last_q, "done beat not last")
  `GPIG_ASSERT_NEXT(a_active_holds, emit && !is_last, act_valid_q, "sequence dropped early")
  `GPIG_ASSERT_IMPL(a_k_in_range, act_valid_q, k_q <= last_k, "result counter past sequence end")

endmodule
